// ----- src/epf_pkg.sv -----
package epf_pkg;

  localparam int VTX_N      = 16;
  localparam int VTX_W      = 4;
  localparam int CELL_N     = VTX_N * VTX_N;
  localparam int CELL_AW    = 2 * VTX_W;
  localparam int CNT_W      = 4;
  localparam int WORK_W     = 5;
  localparam int PATH_DEPTH = 2048;
  localparam int PATH_AW    = 11;
  localparam int LEN_W      = 12;
  localparam int VC_W       = 5;
  localparam int SUM_W      = 13;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BAD   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_ACK   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_RUN  = 2'd1,
    CMD_READ = 2'd2
  } cmd_t;

endpackage

// ----- src/epf_ram.sv -----
module epf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/euler_path_finder.sv -----
// Euler path finder. A load word writes both symmetric cells of the edge-count matrix, one
// in S_LD_A and one in S_LD_B. A run word copies the 256-cell matrix into a work memory
// while summing degrees, then walks the graph with a stack: each matrix cell examined is
// read in S_SC_RD and checked in S_SC_CHK, each step along an edge adds S_PU_B, and a
// rotation scan for an open path reads each stored path vertex in S_ROT and checks it in
// S_ROT_CK. The block takes a new word only when the previous one is finished.
module euler_path_finder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,   // vertex_count
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,      // row_vertex, col_vertex, edge_count, zero pad
  input  logic [1:0]  in_tuser,      // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,     // path_length, vertex_number, zero pad
  output logic [1:0]  out_tuser,     // status
  output logic        out_tlast      // last_vertex
);

  typedef enum logic [4:0] {
    S_IDLE, S_LD_A, S_LD_B, S_RD_W, S_CP, S_FIND, S_VE_R, S_VE_W1, S_VE_W2,
    S_W_INIT, S_SC_RD, S_SC_CHK, S_PU_B, S_POP_W, S_CHK_LEFT, S_ROT, S_ROT_CK, S_DONE
  } state_t;

  state_t state_r;

  logic [epf_pkg::VC_W-1:0]    vc_r;
  logic [epf_pkg::VC_W-1:0]    n_w;
  logic [epf_pkg::VTX_W-1:0]   row_r, col_r;
  logic [epf_pkg::CNT_W-1:0]   cnt_r;
  epf_pkg::status_t            status_r;
  logic [epf_pkg::LEN_W-1:0]   pc_r, rot_r, pos_r;
  logic                        ack_r, last_r;
  logic [epf_pkg::VC_W-1:0]    vnum_r;
  logic                        ov_r;
  logic [epf_pkg::LEN_W-1:0]   out_len_r;
  logic [epf_pkg::VC_W-1:0]    out_vnum_r;
  epf_pkg::status_t            out_st_r;
  logic                        out_last_r;

  logic [epf_pkg::CELL_N-1:0]  adj_vld_r;
  logic                        vld_q_r;
  logic [epf_pkg::CELL_AW:0]   cp_cnt_r;
  logic [epf_pkg::CELL_AW-1:0] pd_addr_r;
  logic                        pd_v_r;
  logic [epf_pkg::VTX_N-1:0]   odd_r, nz_r;
  logic [epf_pkg::SUM_W-1:0]   sum_r;
  logic                        virt_r;
  logic [epf_pkg::VTX_W-1:0]   v1_r, v2_r, top_r, i_r;
  logic [epf_pkg::LEN_W-1:0]   sp_r, len_r, push_cnt_r, k_r;
  logic [epf_pkg::WORK_W-1:0]  dec_r;
  logic [epf_pkg::VTX_W-1:0]   prev_r;

  logic                        adj_we;
  logic [epf_pkg::CELL_AW-1:0] adj_waddr;
  logic [epf_pkg::CNT_W-1:0]   adj_rdata;
  logic [epf_pkg::CNT_W-1:0]   cp_data;
  logic                        wk_we;
  logic [epf_pkg::CELL_AW-1:0] wk_waddr, wk_raddr;
  logic [epf_pkg::WORK_W-1:0]  wk_wdata, wk_rdata;
  logic                        stk_we;
  logic [epf_pkg::PATH_AW-1:0] stk_waddr, stk_raddr;
  logic [epf_pkg::VTX_W-1:0]   stk_wdata, stk_rdata;
  logic                        pth_we;
  logic [epf_pkg::PATH_AW-1:0] pth_raddr;
  logic [epf_pkg::VTX_W-1:0]   pth_rdata;

  logic                        in_fire;
  logic [epf_pkg::VTX_W-1:0]   first_w, v1_w, v2_w;
  logic                        any_w;
  logic [epf_pkg::VC_W-1:0]    odd_cnt_w;
  logic [epf_pkg::LEN_W:0]     idx_sum_w;
  logic [epf_pkg::LEN_W:0]     idx_w;
  logic                        cell_in_w;
  logic                        sc_last_w;
  logic                        pair_w;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = ov_r;
  assign out_tuser  = out_st_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {7'd0, out_vnum_r, out_len_r};

  always_comb begin
    if (vc_r == '0) begin
      n_w = epf_pkg::VC_W'(1);
    end else if (vc_r > epf_pkg::VC_W'(epf_pkg::VTX_N)) begin
      n_w = epf_pkg::VC_W'(epf_pkg::VTX_N);
    end else begin
      n_w = vc_r;
    end
  end

  always_comb begin
    first_w = '0;
    v1_w    = '0;
    v2_w    = '0;
    any_w   = |nz_r;
    for (int k = epf_pkg::VTX_N - 1; k >= 0; k--) begin
      if (nz_r[k]) first_w = epf_pkg::VTX_W'(k);
      if (odd_r[k]) v1_w = epf_pkg::VTX_W'(k);
    end
    for (int k = epf_pkg::VTX_N - 1; k >= 0; k--) begin
      if (odd_r[k] && epf_pkg::VTX_W'(k) > v1_w) v2_w = epf_pkg::VTX_W'(k);
    end
    odd_cnt_w = epf_pkg::VC_W'($countones(odd_r));
  end

  assign idx_sum_w = {1'b0, rot_r} + {1'b0, pos_r};
  assign idx_w     = (rot_r != '0 && idx_sum_w > {1'b0, pc_r}) ?
                     idx_sum_w - {1'b0, pc_r} : idx_sum_w;
  assign cp_data   = vld_q_r ? adj_rdata : '0;
  assign cell_in_w = ({1'b0, pd_addr_r[epf_pkg::CELL_AW-1:epf_pkg::VTX_W]} < n_w) &&
                     ({1'b0, pd_addr_r[epf_pkg::VTX_W-1:0]} < n_w);
  assign sc_last_w = ({1'b0, i_r} == n_w - epf_pkg::VC_W'(1));
  assign pair_w    = (prev_r == v1_r && pth_rdata == v2_r) ||
                     (prev_r == v2_r && pth_rdata == v1_r);

  always_comb begin
    adj_we    = (state_r == S_LD_A || state_r == S_LD_B) && (row_r != col_r);
    adj_waddr = (state_r == S_LD_A) ? {row_r, col_r} : {col_r, row_r};

    wk_we    = 1'b0;
    wk_waddr = pd_addr_r;
    wk_wdata = {1'b0, cp_data};
    wk_raddr = {top_r, i_r};
    case (state_r)
      S_CP: begin
        wk_we = pd_v_r;
      end
      S_VE_R: begin
        wk_raddr = {v1_r, v2_r};
      end
      S_VE_W1: begin
        wk_we    = 1'b1;
        wk_waddr = {v1_r, v2_r};
        wk_wdata = wk_rdata + epf_pkg::WORK_W'(1);
      end
      S_VE_W2: begin
        wk_we    = 1'b1;
        wk_waddr = {v2_r, v1_r};
        wk_wdata = dec_r;
      end
      S_SC_CHK: begin
        wk_we    = (wk_rdata != '0) && !sp_r[epf_pkg::PATH_AW];
        wk_waddr = {top_r, i_r};
        wk_wdata = wk_rdata - epf_pkg::WORK_W'(1);
      end
      S_PU_B: begin
        wk_we    = 1'b1;
        wk_waddr = {i_r, top_r};
        wk_wdata = dec_r;
      end
      default: begin
      end
    endcase

    stk_we    = 1'b0;
    stk_waddr = sp_r[epf_pkg::PATH_AW-1:0];
    stk_wdata = i_r;
    stk_raddr = epf_pkg::PATH_AW'(sp_r - epf_pkg::LEN_W'(2));
    if (state_r == S_W_INIT) begin
      stk_we    = 1'b1;
      stk_waddr = '0;
      stk_wdata = first_w;
    end else if (state_r == S_SC_CHK) begin
      stk_we = (wk_rdata != '0) && !sp_r[epf_pkg::PATH_AW];
    end

    pth_we    = (state_r == S_SC_CHK) && (wk_rdata == '0) && sc_last_w &&
                !len_r[epf_pkg::PATH_AW];
    pth_raddr = (state_r == S_ROT) ? k_r[epf_pkg::PATH_AW-1:0] :
                idx_w[epf_pkg::PATH_AW-1:0];
  end

  epf_ram #(.WIDTH(epf_pkg::CNT_W), .DEPTH(epf_pkg::CELL_N)) u_adj (
    .clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(cnt_r),
    .raddr(cp_cnt_r[epf_pkg::CELL_AW-1:0]), .rdata(adj_rdata)
  );

  epf_ram #(.WIDTH(epf_pkg::WORK_W), .DEPTH(epf_pkg::CELL_N)) u_work (
    .clk(clk), .we(wk_we), .waddr(wk_waddr), .wdata(wk_wdata),
    .raddr(wk_raddr), .rdata(wk_rdata)
  );

  epf_ram #(.WIDTH(epf_pkg::VTX_W), .DEPTH(epf_pkg::PATH_DEPTH)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  epf_ram #(.WIDTH(epf_pkg::VTX_W), .DEPTH(epf_pkg::PATH_DEPTH)) u_path (
    .clk(clk), .we(pth_we), .waddr(len_r[epf_pkg::PATH_AW-1:0]), .wdata(top_r),
    .raddr(pth_raddr), .rdata(pth_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      vc_r      <= epf_pkg::VC_W'(epf_pkg::VTX_N);
      status_r  <= epf_pkg::ST_EMPTY;
      pc_r      <= '0;
      rot_r     <= '0;
      pos_r     <= '0;
      ov_r      <= 1'b0;
      adj_vld_r <= '0;
      pd_v_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) vc_r <= cfg_wr_data;
      if (ov_r && out_tready && state_r != S_DONE) ov_r <= 1'b0;
      if (adj_we) adj_vld_r[adj_waddr] <= 1'b1;
      vld_q_r <= adj_vld_r[cp_cnt_r[epf_pkg::CELL_AW-1:0]];

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            row_r  <= in_tdata[3:0];
            col_r  <= in_tdata[7:4];
            cnt_r  <= in_tdata[11:8];
            ack_r  <= 1'b0;
            vnum_r <= '0;
            last_r <= 1'b0;
            case (in_tuser)
              epf_pkg::CMD_LOAD: begin
                ack_r   <= 1'b1;
                state_r <= S_LD_A;
              end
              epf_pkg::CMD_RUN: begin
                pos_r    <= '0;
                cp_cnt_r <= '0;
                pd_v_r   <= 1'b0;
                odd_r    <= '0;
                nz_r     <= '0;
                sum_r    <= '0;
                state_r  <= S_CP;
              end
              epf_pkg::CMD_READ: begin
                if (status_r == epf_pkg::ST_OK && pos_r < pc_r) begin
                  state_r <= S_RD_W;
                end else begin
                  state_r <= S_DONE;
                end
              end
              default: begin
                state_r <= S_DONE;
              end
            endcase
          end
        end
        S_LD_A: state_r <= S_LD_B;
        S_LD_B: state_r <= S_DONE;
        S_RD_W: begin
          vnum_r  <= {1'b0, pth_rdata} + epf_pkg::VC_W'(1);
          last_r  <= (pos_r + epf_pkg::LEN_W'(1) == pc_r);
          pos_r   <= pos_r + epf_pkg::LEN_W'(1);
          state_r <= S_DONE;
        end
        S_CP: begin
          if (!cp_cnt_r[epf_pkg::CELL_AW]) begin
            cp_cnt_r <= cp_cnt_r + (epf_pkg::CELL_AW + 1)'(1);
          end
          pd_v_r    <= !cp_cnt_r[epf_pkg::CELL_AW];
          pd_addr_r <= cp_cnt_r[epf_pkg::CELL_AW-1:0];
          if (pd_v_r && cell_in_w) begin
            odd_r[pd_addr_r[epf_pkg::CELL_AW-1:epf_pkg::VTX_W]] <=
              odd_r[pd_addr_r[epf_pkg::CELL_AW-1:epf_pkg::VTX_W]] ^ cp_data[0];
            if (cp_data != '0) nz_r[pd_addr_r[epf_pkg::CELL_AW-1:epf_pkg::VTX_W]] <= 1'b1;
            sum_r <= sum_r + epf_pkg::SUM_W'(cp_data);
          end
          if (cp_cnt_r[epf_pkg::CELL_AW] && !pd_v_r) state_r <= S_FIND;
        end
        S_FIND: begin
          v1_r   <= v1_w;
          v2_r   <= v2_w;
          virt_r <= (odd_cnt_w == epf_pkg::VC_W'(2));
          if (!any_w) begin
            status_r <= epf_pkg::ST_EMPTY;
            pc_r     <= '0;
            rot_r    <= '0;
            state_r  <= S_DONE;
          end else if (odd_cnt_w == epf_pkg::VC_W'(2)) begin
            state_r <= S_VE_R;
          end else if (odd_cnt_w == '0) begin
            state_r <= S_W_INIT;
          end else begin
            status_r <= epf_pkg::ST_BAD;
            pc_r     <= '0;
            rot_r    <= '0;
            state_r  <= S_DONE;
          end
        end
        S_VE_R: state_r <= S_VE_W1;
        S_VE_W1: begin
          dec_r   <= wk_rdata + epf_pkg::WORK_W'(1);
          state_r <= S_VE_W2;
        end
        S_VE_W2: state_r <= S_W_INIT;
        S_W_INIT: begin
          sp_r       <= epf_pkg::LEN_W'(1);
          len_r      <= '0;
          push_cnt_r <= '0;
          top_r      <= first_w;
          i_r        <= '0;
          state_r    <= S_SC_RD;
        end
        S_SC_RD: state_r <= S_SC_CHK;
        S_SC_CHK: begin
          if (wk_rdata != '0) begin
            if (sp_r[epf_pkg::PATH_AW]) begin
              status_r <= epf_pkg::ST_BAD;
              pc_r     <= '0;
              rot_r    <= '0;
              state_r  <= S_DONE;
            end else begin
              sp_r       <= sp_r + epf_pkg::LEN_W'(1);
              push_cnt_r <= push_cnt_r + epf_pkg::LEN_W'(1);
              dec_r      <= wk_rdata - epf_pkg::WORK_W'(1);
              state_r    <= S_PU_B;
            end
          end else if (sc_last_w) begin
            if (len_r[epf_pkg::PATH_AW]) begin
              status_r <= epf_pkg::ST_BAD;
              pc_r     <= '0;
              rot_r    <= '0;
              state_r  <= S_DONE;
            end else begin
              len_r <= len_r + epf_pkg::LEN_W'(1);
              sp_r  <= sp_r - epf_pkg::LEN_W'(1);
              if (sp_r == epf_pkg::LEN_W'(1)) begin
                state_r <= S_CHK_LEFT;
              end else begin
                state_r <= S_POP_W;
              end
            end
          end else begin
            i_r     <= i_r + epf_pkg::VTX_W'(1);
            state_r <= S_SC_RD;
          end
        end
        S_PU_B: begin
          top_r   <= i_r;
          i_r     <= '0;
          state_r <= S_SC_RD;
        end
        S_POP_W: begin
          top_r   <= stk_rdata;
          i_r     <= '0;
          state_r <= S_SC_RD;
        end
        S_CHK_LEFT: begin
          if ({push_cnt_r, 1'b0} != sum_r + (virt_r ? epf_pkg::SUM_W'(2) : '0)) begin
            status_r <= epf_pkg::ST_BAD;
            pc_r     <= '0;
            rot_r    <= '0;
            state_r  <= S_DONE;
          end else if (virt_r) begin
            k_r     <= '0;
            state_r <= S_ROT;
          end else begin
            status_r <= epf_pkg::ST_OK;
            pc_r     <= len_r;
            rot_r    <= '0;
            state_r  <= S_DONE;
          end
        end
        S_ROT: state_r <= S_ROT_CK;
        S_ROT_CK: begin
          prev_r <= pth_rdata;
          if (k_r != '0 && pair_w) begin
            status_r <= epf_pkg::ST_OK;
            pc_r     <= len_r - epf_pkg::LEN_W'(1);
            rot_r    <= k_r;
            state_r  <= S_DONE;
          end else if (k_r + epf_pkg::LEN_W'(1) >= len_r) begin
            status_r <= epf_pkg::ST_BAD;
            pc_r     <= '0;
            rot_r    <= '0;
            state_r  <= S_DONE;
          end else begin
            k_r     <= k_r + epf_pkg::LEN_W'(1);
            state_r <= S_ROT;
          end
        end
        S_DONE: begin
          if (!ov_r || out_tready) begin
            ov_r       <= 1'b1;
            out_st_r   <= ack_r ? epf_pkg::ST_ACK : status_r;
            out_len_r  <= ack_r ? '0 : pc_r;
            out_vnum_r <= vnum_r;
            out_last_r <= last_r;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/epf_checker.sv -----
module epf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("Output word dropped while stalled.");

  a_ack_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == epf_pkg::ST_ACK |-> out_tdata == '0 && !out_tlast)
    else $error("Load acknowledge carries payload.");

  a_last_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == epf_pkg::ST_OK && out_tdata[16:12] != '0)
    else $error("Final vertex without a valid path.");

  a_fail_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != epf_pkg::ST_OK |-> out_tdata[11:0] == '0)
    else $error("Failed search reports a path length.");

endmodule

bind euler_path_finder epf_checker u_epf_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
);
